[design/stable_counting_sort_with_tag_defines.svh]
// Assertion macros used by the checker file of the counting sort block.
`ifndef STABLE_COUNTING_SORT_WITH_TAG_DEFINES_SVH
`define STABLE_COUNTING_SORT_WITH_TAG_DEFINES_SVH

// Same-cycle implication under synchronous active-low reset.
`define SCS_ASSERT_IMP(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication under synchronous active-low reset.
`define SCS_ASSERT_NXT(lbl, ck, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/scs_pkg.sv]
// Shared constants and types of the stable counting sort block.
`default_nettype none

package scs_pkg;

  localparam int MAX_ITEMS_DEF = 64;
  localparam int NUM_KEYS_DEF  = 11;
  localparam int TAG_BITS_DEF  = 16;

  localparam int KEY_W       = 4;
  localparam int TAG_FIELD_W = 16;
  localparam int TDATA_W     = 24;

  localparam int Q_DEPTH = 2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PREFIX,
    ST_PLACE,
    ST_EMIT
  } back_state_t;

endpackage

`default_nettype wire

[design/stable_counting_sort_with_tag.sv]
// Top level of the stable counting sort of tagged items.
//
// Input beats carry a key and a tag; tlast closes a set. Keys above
// NUM_KEYS-1 are clamped, tags are kept to TAG_BITS bits. Up to MAX_ITEMS
// beats of a set are stored; further beats are discarded and flagged.
// Once the closing beat is taken, the set comes out in ascending key order,
// equal keys in arrival order, one beat per stored item; tlast marks the
// final beat and tuser on it is high if any beats were discarded.
// Per set of n stored items: the engine loads one beat per cycle while
// in its load state (through a two-entry input queue), forms running sums
// over the NUM_KEYS counters, places the items through the item RAM read
// port, then sends n output beats at one per cycle while the receiver is
// ready. The input queue keeps taking beats of the next set while the
// engine sorts until it holds two of them.
// A stalled receiver holds the output beat steady and pauses emission.
// Reset empties the queue and returns the engine to loading; the RAMs
// need no clearing.
`default_nettype none

module stable_counting_sort_with_tag #(
  parameter int MAX_ITEMS = scs_pkg::MAX_ITEMS_DEF,
  parameter int NUM_KEYS  = scs_pkg::NUM_KEYS_DEF,
  parameter int TAG_BITS  = scs_pkg::TAG_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [scs_pkg::TDATA_W-1:0] in_tdata,   // key[3:0], tag[19:4], pad
  input  wire logic                        in_tlast,   // last
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic      [scs_pkg::TDATA_W-1:0] out_tdata,  // sorted_key[3:0], sorted_tag[19:4]
  output logic                             out_tlast,  // last_out
  output logic                             out_tuser   // dropped
);

  localparam int TAG_W = (TAG_BITS < scs_pkg::TAG_FIELD_W) ? TAG_BITS : scs_pkg::TAG_FIELD_W;

  logic                      q_valid;
  logic                      q_ready;
  logic [scs_pkg::KEY_W-1:0] q_key;
  logic [TAG_W-1:0]          q_tag;
  logic                      q_last;
  logic [scs_pkg::KEY_W-1:0] out_key;
  logic [TAG_W-1:0]          out_tag;
  logic [scs_pkg::TAG_FIELD_W-1:0] out_tag_ext;

  scs_front #(
    .NUM_KEYS (NUM_KEYS),
    .TAG_BITS (TAG_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_key     (q_key),
    .q_tag     (q_tag),
    .q_last    (q_last)
  );

  scs_back #(
    .MAX_ITEMS (MAX_ITEMS),
    .NUM_KEYS  (NUM_KEYS),
    .TAG_BITS  (TAG_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_key       (q_key),
    .q_tag       (q_tag),
    .q_last      (q_last),
    .out_valid_r (out_tvalid),
    .out_ready   (out_tready),
    .out_key     (out_key),
    .out_tag     (out_tag),
    .out_last_r  (out_tlast),
    .out_drop_r  (out_tuser)
  );

  assign out_tag_ext = scs_pkg::TAG_FIELD_W'(out_tag);
  assign out_tdata   = scs_pkg::TDATA_W'({out_tag_ext, out_key});

endmodule

`default_nettype wire

[design/scs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module scs_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[design/scs_front.sv]
// Input side: unpack, saturate key, mask tag, and queue beats for the sorter.
`default_nettype none

module scs_front #(
  parameter int NUM_KEYS = scs_pkg::NUM_KEYS_DEF,
  parameter int TAG_BITS = scs_pkg::TAG_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [scs_pkg::TDATA_W-1:0]         in_tdata,
  input  wire logic                                in_tlast,
  output logic                                     q_valid,
  input  wire logic                                q_ready,
  output logic      [scs_pkg::KEY_W-1:0]           q_key,
  output logic      [((TAG_BITS < scs_pkg::TAG_FIELD_W) ?
                      TAG_BITS : scs_pkg::TAG_FIELD_W)-1:0] q_tag,
  output logic                                     q_last
);

  localparam int TAG_W = (TAG_BITS < scs_pkg::TAG_FIELD_W) ? TAG_BITS : scs_pkg::TAG_FIELD_W;
  localparam int PW    = $clog2(scs_pkg::Q_DEPTH);
  localparam int CNTW  = $clog2(scs_pkg::Q_DEPTH + 1);
  localparam logic [scs_pkg::KEY_W:0]   KEY_LIM = (scs_pkg::KEY_W + 1)'(NUM_KEYS);
  localparam logic [scs_pkg::KEY_W-1:0] KEY_MAX = scs_pkg::KEY_W'(NUM_KEYS - 1);

  logic [scs_pkg::KEY_W-1:0] key_raw;
  logic [scs_pkg::KEY_W-1:0] key_sat;
  logic [TAG_W-1:0]          tag_in;
  logic                      push;
  logic                      pop;

  logic [scs_pkg::KEY_W-1:0] ent_key_r  [scs_pkg::Q_DEPTH];
  logic [TAG_W-1:0]          ent_tag_r  [scs_pkg::Q_DEPTH];
  logic                      ent_last_r [scs_pkg::Q_DEPTH];
  logic [PW-1:0]             wr_ptr_r;
  logic [PW-1:0]             rd_ptr_r;
  logic [CNTW-1:0]           cnt_r;
  logic [PW-1:0]             wr_ptr_nxt;
  logic [PW-1:0]             rd_ptr_nxt;
  logic [CNTW-1:0]           cnt_nxt;

  assign key_raw = in_tdata[scs_pkg::KEY_W-1:0];
  assign key_sat = ({1'b0, key_raw} >= KEY_LIM) ? KEY_MAX : key_raw;
  assign tag_in  = in_tdata[scs_pkg::KEY_W +: TAG_W];

  assign in_tready = (cnt_r != CNTW'(scs_pkg::Q_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  assign q_key  = ent_key_r[rd_ptr_r];
  assign q_tag  = ent_tag_r[rd_ptr_r];
  assign q_last = ent_last_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? PW'(wr_ptr_r + PW'(1)) : wr_ptr_r;
    rd_ptr_nxt = pop ? PW'(rd_ptr_r + PW'(1)) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_key_r[wr_ptr_r]  <= key_sat;
      ent_tag_r[wr_ptr_r]  <= tag_in;
      ent_last_r[wr_ptr_r] <= in_tlast;
    end
  end

endmodule

`default_nettype wire

[design/scs_back.sv]
// Sort engine: load and count, running sums, stable placement, sorted emission.
`default_nettype none

module scs_back #(
  parameter int MAX_ITEMS = scs_pkg::MAX_ITEMS_DEF,
  parameter int NUM_KEYS  = scs_pkg::NUM_KEYS_DEF,
  parameter int TAG_BITS  = scs_pkg::TAG_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                q_valid,
  output logic                                     q_ready,
  input  wire logic [scs_pkg::KEY_W-1:0]           q_key,
  input  wire logic [((TAG_BITS < scs_pkg::TAG_FIELD_W) ?
                      TAG_BITS : scs_pkg::TAG_FIELD_W)-1:0] q_tag,
  input  wire logic                                q_last,
  output logic                                     out_valid_r,
  input  wire logic                                out_ready,
  output logic      [scs_pkg::KEY_W-1:0]           out_key,
  output logic      [((TAG_BITS < scs_pkg::TAG_FIELD_W) ?
                      TAG_BITS : scs_pkg::TAG_FIELD_W)-1:0] out_tag,
  output logic                                     out_last_r,
  output logic                                     out_drop_r
);

  localparam int TAG_W = (TAG_BITS < scs_pkg::TAG_FIELD_W) ? TAG_BITS : scs_pkg::TAG_FIELD_W;
  localparam int IW    = scs_pkg::KEY_W + TAG_W;
  localparam int AW    = $clog2(MAX_ITEMS);
  localparam int CW    = $clog2(MAX_ITEMS + 1);
  localparam int KW    = $clog2(NUM_KEYS);

  scs_pkg::back_state_t state_r, state_nxt;

  logic [CW-1:0] bucket_r [NUM_KEYS];
  logic [CW-1:0] bucket_nxt [NUM_KEYS];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic [KW-1:0] pidx_r, pidx_nxt;
  logic [CW-1:0] run_r, run_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          pl_v_r, pl_v_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          out_valid_nxt;
  logic          out_last_nxt;
  logic          out_drop_nxt;

  logic          item_we;
  logic          item_re;
  logic [AW-1:0] item_raddr;
  logic [IW-1:0] item_rdata;
  logic          out_we;
  logic [AW-1:0] out_waddr;
  logic          out_re;
  logic [IW-1:0] out_rdata;

  logic [KW-1:0] load_k;
  logic [KW-1:0] place_k;
  logic [CW-1:0] prefix_sum;
  logic [CW-1:0] place_pos;
  logic          emit_last;

  scs_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_ITEMS)
  ) u_item_ram (
    .clk     (clk),
    .we      (item_we),
    .waddr   (cnt_r[AW-1:0]),
    .wdata   ({q_tag, q_key}),
    .re      (item_re),
    .raddr   (item_raddr),
    .rdata_r (item_rdata)
  );

  scs_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_ITEMS)
  ) u_out_ram (
    .clk     (clk),
    .we      (out_we),
    .waddr   (out_waddr),
    .wdata   (item_rdata),
    .re      (out_re),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (out_rdata)
  );

  assign out_key = out_rdata[scs_pkg::KEY_W-1:0];
  assign out_tag = out_rdata[IW-1:scs_pkg::KEY_W];

  assign load_k     = q_key[KW-1:0];
  assign place_k    = item_rdata[KW-1:0];
  assign prefix_sum = run_r + bucket_r[pidx_r];
  assign place_pos  = bucket_r[place_k] - CW'(1);
  assign emit_last  = ((idx_r + CW'(1)) == cnt_r);
  assign item_raddr = AW'(rem_r - CW'(1));
  assign out_waddr  = place_pos[AW-1:0];

  always_comb begin
    state_nxt  = state_r;
    bucket_nxt = bucket_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    pidx_nxt   = pidx_r;
    run_nxt    = run_r;
    rem_nxt    = rem_r;
    pl_v_nxt   = 1'b0;
    idx_nxt    = idx_r;
    q_ready    = 1'b0;
    item_we    = 1'b0;
    item_re    = 1'b0;
    out_we     = 1'b0;
    out_re     = 1'b0;

    unique case (state_r)
      scs_pkg::ST_LOAD: begin
        q_ready = 1'b1;
        if (q_valid) begin
          if (cnt_r < CW'(MAX_ITEMS)) begin
            item_we            = 1'b1;
            bucket_nxt[load_k] = bucket_r[load_k] + CW'(1);
            cnt_nxt            = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (q_last) begin
            state_nxt = scs_pkg::ST_PREFIX;
            pidx_nxt  = '0;
            run_nxt   = '0;
          end
        end
      end
      scs_pkg::ST_PREFIX: begin
        bucket_nxt[pidx_r] = prefix_sum;
        run_nxt            = prefix_sum;
        pidx_nxt           = pidx_r + KW'(1);
        if (pidx_r == KW'(NUM_KEYS - 1)) begin
          state_nxt = scs_pkg::ST_PLACE;
          rem_nxt   = cnt_r;
        end
      end
      scs_pkg::ST_PLACE: begin
        if (rem_r != '0) begin
          item_re  = 1'b1;
          rem_nxt  = rem_r - CW'(1);
          pl_v_nxt = 1'b1;
        end
        if (pl_v_r && (bucket_r[place_k] != '0)) begin
          out_we              = 1'b1;
          bucket_nxt[place_k] = place_pos;
        end
        if ((rem_r == '0) && !pl_v_r) begin
          state_nxt  = scs_pkg::ST_EMIT;
          idx_nxt    = '0;
          bucket_nxt = '{default: '0};
        end
      end
      scs_pkg::ST_EMIT: begin
        if ((idx_r != cnt_r) && (!out_valid_r || out_ready)) begin
          out_re  = 1'b1;
          idx_nxt = idx_r + CW'(1);
          if (emit_last) begin
            state_nxt = scs_pkg::ST_LOAD;
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = scs_pkg::ST_LOAD;
      end
    endcase

    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    if (out_re) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = emit_last;
      out_drop_nxt  = emit_last && ovf_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scs_pkg::ST_LOAD;
      bucket_r    <= '{default: '0};
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      pidx_r      <= '0;
      run_r       <= '0;
      rem_r       <= '0;
      pl_v_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      out_drop_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bucket_r    <= bucket_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      pidx_r      <= pidx_nxt;
      run_r       <= run_nxt;
      rem_r       <= rem_nxt;
      pl_v_r      <= pl_v_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      out_drop_r  <= out_drop_nxt;
    end
  end

endmodule

`default_nettype wire

[design/scs_checker.sv]
// Port-level checks on the sorted output stream, bound to the top level.
`default_nettype none
`include "stable_counting_sort_with_tag_defines.svh"

module scs_checker #(
  parameter int NUM_KEYS = scs_pkg::NUM_KEYS_DEF
) (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [scs_pkg::TDATA_W-1:0] out_tdata,
  input wire logic                        out_tlast,
  input wire logic                        out_tuser
);

  `SCS_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output beat changed")
  `SCS_ASSERT_IMP(a_drop_on_last, clk, rst_n, out_tvalid && out_tuser, out_tlast, "drop flag on a beat that is not last")
  `SCS_ASSERT_IMP(a_key_range, clk, rst_n, out_tvalid, out_tdata[scs_pkg::KEY_W-1:0] <= scs_pkg::KEY_W'(NUM_KEYS - 1), "sorted key out of range")
  `SCS_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[scs_pkg::TDATA_W-1:scs_pkg::KEY_W + scs_pkg::TAG_FIELD_W] == '0, "output padding not zero")

endmodule

bind stable_counting_sort_with_tag scs_checker #(
  .NUM_KEYS (NUM_KEYS)
) u_scs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
